/* design/ssv_pkg.sv */
// shared types and constants of the shaped sine voice: payload structs, field codes,
// register indexes and the quarter-wave sine table builder
// no dependencies
`default_nettype none

package ssv_pkg;

  localparam int unsigned SINE_TABLE_DEPTH = 1024;
  localparam int unsigned PHASE_BITS       = 16;

  localparam int unsigned SINE_AW      = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned SINE_QUARTER = SINE_TABLE_DEPTH / 4;
  localparam int unsigned SINE_KW      = SINE_AW - 1;
  localparam int unsigned IDX_SHIFT    = PHASE_BITS - SINE_AW;
  localparam int unsigned MAG_W        = 15;

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_AMPLITUDE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_STEP       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_STEP      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_RELEASE_STEP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_VOLUME     = 3'd4;

  localparam logic       CMD_START  = 1'b0;
  localparam logic       CMD_SAMPLE = 1'b1;
  localparam logic [1:0] MODE_HELD         = 2'd0;
  localparam logic [1:0] MODE_RELEASED     = 2'd1;
  localparam logic [1:0] MODE_FAST_RELEASE = 2'd2;
  localparam logic [1:0] MODE_SILENT       = 2'd3;

  // odd polynomial coefficients of sin(pi/2 * x), Q30
  localparam logic [63:0] COEF_A1 = 64'd1686629713;
  localparam logic [63:0] COEF_A3 = 64'd693598669;
  localparam logic [63:0] COEF_A5 = 64'd85569306;
  localparam logic [63:0] COEF_A7 = 64'd5026991;
  localparam logic [63:0] COEF_A9 = 64'd172271;

  typedef struct packed {
    logic               cmd;
    logic [1:0]         mode;
    logic [14:0]        phase_step;
    logic signed [15:0] mix_in;
  } ssv_in_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               note_ended;
  } ssv_out_t;

  typedef logic [MAG_W-1:0] sine_rom_t [SINE_QUARTER+1];

  // quarter-wave magnitudes, entry k is sin(pi/2 * k / quarter) in Q0.15
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] p;
    logic [63:0] m;
    for (int k = 0; k <= int'(SINE_QUARTER); k++) begin
      x  = 64'(k) << (32 - SINE_AW);
      x2 = (x * x) >> 30;
      p  = COEF_A9;
      p  = COEF_A7 - ((x2 * p) >> 30);
      p  = COEF_A5 - ((x2 * p) >> 30);
      p  = COEF_A3 - ((x2 * p) >> 30);
      p  = COEF_A1 - ((x2 * p) >> 30);
      m  = (((x * p) >> 30) + 64'd16384) >> 15;
      rom[k] = (m > 64'd32767) ? 15'h7fff : m[MAG_W-1:0];
    end
    return rom;
  endfunction

endpackage

`default_nettype wire

/* design/shaped_sine_voice_with_envelope_core.sv */
// a sample request runs the whole step program, a start or silent request jumps from the
// dispatch step straight to finish; the finish step waits while the output register is full,
// and a new request is taken only once the result has been handed on; requests run one at a
// time through the seven-word step program over one shared 31x16 multiplier
// reset: registers take their reset values, phase, amplitude and end mark clear at once
`default_nettype none

module shaped_sine_voice_with_envelope_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ssv_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [15:0]                     cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  ssv_pkg::ssv_in_t                in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output ssv_pkg::ssv_out_t               out_data_o
);
  import ssv_pkg::*;

  typedef enum logic [1:0] {OP_DISPATCH, OP_MUL, OP_FINISH} op_e;
  typedef enum logic {A_ROM, A_ACC} a_sel_e;
  typedef enum logic [1:0] {B_ROM, B_ACC, B_AMP, B_VOL} b_sel_e;
  typedef enum logic [1:0] {WR_RND15, WR_FULL, WR_RND32} wr_e;

  typedef struct packed {
    op_e        op;
    a_sel_e     a_sel;
    b_sel_e     b_sel;
    wr_e        wr;
    logic       bypass_jmp;
    logic [2:0] target;
  } uword_t;

  localparam logic [2:0] STEP_DISPATCH = 3'd0;
  localparam logic [2:0] STEP_FINISH   = 3'd6;

  // step program: envelope and rom read, x^2, x^4, x^5, * amplitude, * volume, finish
  function automatic uword_t ucode(input logic [2:0] pc);
    uword_t w;
    w = '{op: OP_FINISH, a_sel: A_ACC, b_sel: B_ACC, wr: WR_RND15,
          bypass_jmp: 1'b0, target: STEP_DISPATCH};
    unique case (pc)
      3'd0: w = '{op: OP_DISPATCH, a_sel: A_ROM, b_sel: B_ROM, wr: WR_RND15,
                  bypass_jmp: 1'b1, target: STEP_FINISH};
      3'd1: w = '{op: OP_MUL, a_sel: A_ROM, b_sel: B_ROM, wr: WR_RND15,
                  bypass_jmp: 1'b0, target: STEP_DISPATCH};
      3'd2: w = '{op: OP_MUL, a_sel: A_ACC, b_sel: B_ACC, wr: WR_RND15,
                  bypass_jmp: 1'b0, target: STEP_DISPATCH};
      3'd3: w = '{op: OP_MUL, a_sel: A_ACC, b_sel: B_ROM, wr: WR_RND15,
                  bypass_jmp: 1'b0, target: STEP_DISPATCH};
      3'd4: w = '{op: OP_MUL, a_sel: A_ACC, b_sel: B_AMP, wr: WR_FULL,
                  bypass_jmp: 1'b0, target: STEP_DISPATCH};
      3'd5: w = '{op: OP_MUL, a_sel: A_ACC, b_sel: B_VOL, wr: WR_RND32,
                  bypass_jmp: 1'b0, target: STEP_DISPATCH};
      default: w = '{op: OP_FINISH, a_sel: A_ACC, b_sel: B_ACC, wr: WR_RND15,
                     bypass_jmp: 1'b0, target: STEP_DISPATCH};
    endcase
    return w;
  endfunction

  logic [15:0] max_amp_q, attack_q, release_q, fast_q, volume_q;
  logic [PHASE_BITS-1:0] phase_q;
  logic [15:0] amp_q;
  logic        end_rep_q;
  logic        busy_q;
  logic [2:0]  pc_q;
  logic        active_q;
  logic        ended_q;
  logic        out_valid_q;
  ssv_in_t     in_q;
  ssv_out_t    out_q;
  logic [30:0] acc_q;

  uword_t              uw;
  logic [SINE_AW-1:0]  rom_idx;
  logic [MAG_W-1:0]    rom_mag;
  logic                neg;
  logic [30:0]         mul_a;
  logic [15:0]         mul_b;
  logic [46:0]         prod;
  logic [46:0]         rnd15;
  logic [47:0]         rnd32;
  logic [30:0]         acc_d;
  logic                bypass;
  logic                out_free;
  logic [15:0]         amp_env;
  logic                end_env;
  logic                ended_env;
  logic [16:0]         att_sum;
  logic [15:0]         dec;
  logic signed [16:0]  voice_s;
  logic signed [16:0]  sum;
  logic signed [15:0]  sample_sat;

  assign uw = ucode(pc_q);

  assign rom_idx = phase_q[PHASE_BITS-1:IDX_SHIFT];
  assign neg     = rom_idx[SINE_AW-1];

  ssv_sine_rom u_rom (
    .clk_i (clk_i),
    .idx_i (rom_idx),
    .mag_o (rom_mag)
  );

  // shared multiplier
  assign mul_a = (uw.a_sel == A_ROM) ? {16'b0, rom_mag} : acc_q;

  always_comb begin
    unique case (uw.b_sel)
      B_ROM:   mul_b = {1'b0, rom_mag};
      B_ACC:   mul_b = acc_q[15:0];
      B_AMP:   mul_b = amp_q;
      default: mul_b = volume_q;
    endcase
  end

  assign prod  = {16'b0, mul_a} * {31'b0, mul_b};
  assign rnd15 = prod + 47'd16384;
  assign rnd32 = {1'b0, prod} + 48'h0000_8000_0000;

  always_comb begin
    unique case (uw.wr)
      WR_RND15: acc_d = rnd15[45:15];
      WR_FULL:  acc_d = prod[30:0];
      default:  acc_d = {15'b0, rnd32[47:32]};
    endcase
  end

  assign bypass   = (in_q.cmd == CMD_START) || (in_q.mode == MODE_SILENT);
  assign out_free = !out_valid_q || !out_stall_i;

  // envelope step for a sample request
  assign att_sum = {1'b0, amp_q} + {1'b0, attack_q};
  assign dec     = (in_q.mode == MODE_RELEASED) ? release_q : fast_q;

  always_comb begin
    amp_env   = amp_q;
    end_env   = end_rep_q;
    ended_env = 1'b0;
    if (in_q.mode == MODE_HELD) begin
      if (amp_q < max_amp_q) begin
        amp_env = (att_sum > {1'b0, max_amp_q}) ? max_amp_q : att_sum[15:0];
      end
    end else if (amp_q != 16'd0) begin
      amp_env = (amp_q > dec) ? (amp_q - dec) : 16'd0;
    end else if (!end_rep_q) begin
      end_env   = 1'b1;
      ended_env = 1'b1;
    end
  end

  // mix and saturate
  assign voice_s = !active_q ? 17'sd0 :
                   neg       ? -$signed({1'b0, acc_q[15:0]}) : $signed({1'b0, acc_q[15:0]});
  assign sum     = {in_q.mix_in[15], in_q.mix_in} + voice_s;

  always_comb begin
    priority if (sum > 17'sd32767) begin
      sample_sat = 16'sh7fff;
    end else if (sum < -17'sd32768) begin
      sample_sat = 16'sh8000;
    end else begin
      sample_sat = sum[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_amp_q   <= 16'd65535;
      attack_q    <= 16'd64;
      release_q   <= 16'd16;
      fast_q      <= 16'd256;
      volume_q    <= 16'd65535;
      phase_q     <= '0;
      amp_q       <= '0;
      end_rep_q   <= 1'b0;
      busy_q      <= 1'b0;
      pc_q        <= STEP_DISPATCH;
      active_q    <= 1'b0;
      ended_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MAX_AMPLITUDE:     max_amp_q <= cfg_wdata_i;
          CFG_ATTACK_STEP:       attack_q  <= cfg_wdata_i;
          CFG_RELEASE_STEP:      release_q <= cfg_wdata_i;
          CFG_FAST_RELEASE_STEP: fast_q    <= cfg_wdata_i;
          CFG_GLOBAL_VOLUME:     volume_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (busy_q && uw.op == OP_FINISH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (!busy_q) begin
        if (in_valid_i) begin
          busy_q <= 1'b1;
          pc_q   <= STEP_DISPATCH;
        end
      end else begin
        unique case (uw.op)
          OP_DISPATCH: begin
            ended_q  <= ended_env && !bypass;
            active_q <= !bypass;
            if (in_q.cmd == CMD_START) begin
              phase_q   <= '0;
              amp_q     <= '0;
              end_rep_q <= 1'b0;
            end else if (in_q.mode != MODE_SILENT) begin
              amp_q     <= amp_env;
              end_rep_q <= end_env;
            end
            pc_q <= (uw.bypass_jmp && bypass) ? uw.target : 3'(pc_q + 3'd1);
          end
          OP_MUL: begin
            pc_q <= 3'(pc_q + 3'd1);
          end
          default: begin
            // result waits here until the output register is free
            if (out_free) begin
              busy_q      <= 1'b0;
              pc_q        <= STEP_DISPATCH;
              if (active_q) begin
                phase_q <= phase_q + PHASE_BITS'(in_q.phase_step);
              end
            end
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (!busy_q && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (busy_q && uw.op == OP_MUL) begin
      acc_q <= acc_d;
    end
    if (busy_q && uw.op == OP_FINISH && out_free) begin
      out_q.sample     <= sample_sat;
      out_q.note_ended <= ended_q;
    end
  end

  assign in_stall_o  = busy_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (busy_q && pc_q == STEP_DISPATCH))
    else $error("accepted request did not start the step program");

  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (pc_q <= STEP_FINISH))
    else $error("step counter ran past the program");

  a_finish_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && uw.op == OP_FINISH && !out_free) |=> (busy_q && pc_q == STEP_FINISH))
    else $error("finish step left while output register was full");

  a_ended_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ended_q |-> (end_rep_q && active_q))
    else $error("note end flagged without end mark");
`endif

endmodule

`default_nettype wire

/* design/ssv_sine_rom.sv */
// sine magnitude rom: folds a full-wave table index onto the quarter wave
// and returns the magnitude from a register in the following cycle; depends on ssv_pkg
`default_nettype none

module ssv_sine_rom (
  input  logic                       clk_i,
  input  logic [ssv_pkg::SINE_AW-1:0] idx_i,
  output logic [ssv_pkg::MAG_W-1:0]   mag_o
);
  import ssv_pkg::*;

  localparam sine_rom_t Rom = build_sine_rom();

  logic [SINE_AW-3:0] low;
  logic [SINE_KW-1:0] k;
  logic [MAG_W-1:0]   mag_q;

  assign low = idx_i[SINE_AW-3:0];

  // odd quadrants run the quarter wave backwards
  assign k = idx_i[SINE_AW-2] ? (SINE_KW'(SINE_QUARTER) - {1'b0, low}) : {1'b0, low};

  always_ff @(posedge clk_i) begin
    mag_q <= Rom[k];
  end

  assign mag_o = mag_q;

endmodule

`default_nettype wire

/* tb/ssv_voice_checker.sv */
// request/result checker for the shaped sine voice: tracks config writes, predicts each
// voice sample with its own envelope and sine model, compares results in order
// depends on ssv_pkg for the payload structs, field codes and register indexes
module ssv_voice_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ssv_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [15:0]                   cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  ssv_pkg::ssv_in_t              in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  ssv_pkg::ssv_out_t             out_data_i,
  output int unsigned                   fail_cnt_o,
  output int unsigned                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ssv_pkg::*;

  // sin(pi/2 * x) odd polynomial, Q30
  localparam logic [63:0] Q30_ONE = 64'd1073741824;
  localparam logic [63:0] K1 = 64'd1686629713;
  localparam logic [63:0] K3 = 64'd693598669;
  localparam logic [63:0] K5 = 64'd85569306;
  localparam logic [63:0] K7 = 64'd5026991;
  localparam logic [63:0] K9 = 64'd172271;

  logic [15:0] max_amp, attack_step, release_step, fast_step, volume;
  logic [PHASE_BITS-1:0] phase;
  logic [15:0] amp;
  logic        end_seen;

  ssv_out_t expected_q [$];
  ssv_out_t exp_res;

  function automatic logic [14:0] sine_mag(input logic [63:0] idx, output logic neg);
    logic [63:0] u, quad, r, x, x2, p, m;
    u    = (idx << 32) / 64'(SINE_TABLE_DEPTH);
    quad = (u >> 30) & 64'd3;
    r    = u & (Q30_ONE - 64'd1);
    x    = quad[0] ? (Q30_ONE - r) : r;
    x2   = (x * x) >> 30;
    p    = K9;
    p    = K7 - ((x2 * p) >> 30);
    p    = K5 - ((x2 * p) >> 30);
    p    = K3 - ((x2 * p) >> 30);
    p    = K1 - ((x2 * p) >> 30);
    m    = (((x * p) >> 30) + 64'd16384) >> 15;
    if (m > 64'd32767) m = 64'd32767;
    neg = (quad >= 64'd2) && (m != 64'd0);
    return m[14:0];
  endfunction

  function automatic logic [63:0] q15_mul(input logic [63:0] a, input logic [63:0] b);
    return (a * b + 64'd16384) >> 15;
  endfunction

  // advances the voice state by one request and returns the result it should give
  function automatic ssv_out_t next_voice_sample(input ssv_in_t rq);
    ssv_out_t    res;
    logic        neg;
    logic [63:0] m, m2, m4, m5, prod, idx;
    logic [16:0] raised;
    logic [15:0] dec;
    int          mix, voice, sum;
    mix            = $signed(rq.mix_in);
    sum            = mix;
    res.note_ended = 1'b0;
    if (rq.cmd == CMD_START) begin
      phase    = '0;
      amp      = '0;
      end_seen = 1'b0;
    end else if (rq.mode != MODE_SILENT) begin
      if (rq.mode == MODE_HELD) begin
        // a lowered ceiling leaves a higher amplitude alone
        if (amp < max_amp) begin
          raised = 17'(amp) + 17'(attack_step);
          amp    = (raised > 17'(max_amp)) ? max_amp : raised[15:0];
        end
      end else begin
        dec = (rq.mode == MODE_RELEASED) ? release_step : fast_step;
        if (amp != '0) begin
          amp = (amp > dec) ? (amp - dec) : '0;
        end else if (!end_seen) begin
          end_seen       = 1'b1;
          res.note_ended = 1'b1;
        end
      end
      idx   = (64'(phase) * 64'(SINE_TABLE_DEPTH)) >> PHASE_BITS;
      m     = 64'(sine_mag(idx, neg));
      m2    = q15_mul(m, m);
      m4    = q15_mul(m2, m2);
      m5    = q15_mul(m4, m);
      prod  = m5 * 64'(amp) * 64'(volume);
      voice = int'((prod + 64'h8000_0000) >> 32);
      if (neg) voice = -voice;
      sum = mix + voice;
      if (sum > 32767) sum = 32767;
      if (sum < -32768) sum = -32768;
      phase = phase + PHASE_BITS'(rq.phase_step);
    end
    res.sample = 16'(sum);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_amp      = 16'd65535;
      attack_step  = 16'd64;
      release_step = 16'd16;
      fast_step    = 16'd256;
      volume       = 16'd65535;
      phase        = '0;
      amp          = '0;
      end_seen     = 1'b0;
      expected_q.delete();
      fail_cnt_o   = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MAX_AMPLITUDE:     max_amp      = cfg_wdata_i;
          CFG_ATTACK_STEP:       attack_step  = cfg_wdata_i;
          CFG_RELEASE_STEP:      release_step = cfg_wdata_i;
          CFG_FAST_RELEASE_STEP: fast_step    = cfg_wdata_i;
          CFG_GLOBAL_VOLUME:     volume       = cfg_wdata_i;
          default: ;
        endcase
      end
      // results first: a request taken at this edge cannot have answered yet
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result: sample %0d note_ended %0b",
                 out_data_i.sample, out_data_i.note_ended);
          fail_cnt_o++;
        end else begin
          exp_res = expected_q.pop_front();
          if (out_data_i.sample !== exp_res.sample) begin
            $error("sample: expected %0d, actual %0d", exp_res.sample, out_data_i.sample);
            fail_cnt_o++;
          end
          if (out_data_i.note_ended !== exp_res.note_ended) begin
            $error("note_ended: expected %0b, actual %0b",
                   exp_res.note_ended, out_data_i.note_ended);
            fail_cnt_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) expected_q.push_back(next_voice_sample(in_data_i));
      pending_o = expected_q.size();
    end
  end

endmodule

/* tb/tb.sv */
// top of the shaped sine voice testbench: clock, reset, request stimulus, config writes
// and result back-pressure; checking is done by ssv_voice_checker
// depends on ssv_pkg, shaped_sine_voice_with_envelope_core and ssv_voice_checker
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ssv_pkg::*;

  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned SET_ITEMS   = 54;
  localparam int unsigned SETTLE_CYC  = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [15:0]          cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  ssv_in_t              in_data;
  logic                 out_valid;
  logic                 out_stall;
  ssv_out_t             out_data;
  int unsigned          fail_cnt;
  int unsigned          pending;

  int unsigned snd_idle;
  int unsigned rcv_idle;
  int unsigned hold_reqs;
  int unsigned hold_served;
  int unsigned sent;

  shaped_sine_voice_with_envelope_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  ssv_voice_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // result back-pressure, with a long hold-off whenever one is asked for
  always begin
    @(negedge clk);
    if (hold_reqs != hold_served) begin
      out_stall = 1'b1;
      repeat (HOLD_CYCLES - 1) @(negedge clk);
      hold_served++;
    end else begin
      out_stall = ($urandom_range(0, 99) < rcv_idle);
    end
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic ssv_in_t make_req(logic cmd, logic [1:0] mode, int unsigned step,
                                       int unsigned mix);
    ssv_in_t r;
    r.cmd        = cmd;
    r.mode       = mode;
    r.phase_step = 15'(step);
    r.mix_in     = 16'(mix);
    return r;
  endfunction

  function automatic ssv_in_t rand_req(logic cmd, logic [1:0] mode);
    return make_req(cmd, mode, $urandom_range(0, 32767), $urandom_range(0, 65535));
  endfunction

  // called and left at a falling edge; valid stays up after acceptance
  task automatic send_req(input ssv_in_t rq);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = rq;
    do @(posedge clk); while (in_stall);
    sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // wait until every request has answered and the core has gone quiet
  task automatic settle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic apply_setting(input int unsigned s);
    logic [15:0] mx, at, rl, fr, vol;
    case (s)
      0: begin
        mx  = 16'($urandom);
        at  = 16'($urandom);
        rl  = 16'($urandom);
        fr  = 16'($urandom);
        vol = 16'($urandom);
      end
      1: begin
        mx = 16'hffff; at = 16'hffff; rl = 16'hffff; fr = 16'hffff; vol = 16'hffff;
      end
      2: begin
        mx = 16'h0000; at = 16'h0000; rl = 16'h0000; fr = 16'h0000; vol = 16'h0000;
      end
      default: begin
        mx  = 16'($urandom_range(20000, 65535));
        at  = 16'($urandom_range(1000, 20000));
        rl  = 16'($urandom_range(500, 8000));
        fr  = 16'($urandom_range(4000, 30000));
        vol = 16'($urandom);
      end
    endcase
    write_reg(CFG_MAX_AMPLITUDE, mx);
    write_reg(CFG_ATTACK_STEP, at);
    write_reg(CFG_RELEASE_STEP, rl);
    write_reg(CFG_FAST_RELEASE_STEP, fr);
    write_reg(CFG_GLOBAL_VOLUME, vol);
  endtask

  // start, attack, then release until the note likely ends; some noise mixed in
  task automatic play_note();
    int unsigned n_held, n_rel;
    logic [1:0]  mode;
    n_held = $urandom_range(0, 10);
    n_rel  = $urandom_range(1, 20);
    send_req(rand_req(CMD_START, 2'($urandom_range(0, 3))));
    repeat (n_held) begin
      mode = ($urandom_range(0, 9) == 0) ? MODE_SILENT : MODE_HELD;
      send_req(rand_req(CMD_SAMPLE, mode));
    end
    repeat (n_rel) begin
      if ($urandom_range(0, 9) == 0) begin
        send_req(rand_req(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3))));
      end else begin
        mode = $urandom_range(0, 1) ? MODE_RELEASED : MODE_FAST_RELEASE;
        send_req(rand_req(CMD_SAMPLE, mode));
      end
    end
  endtask

  initial begin
    int unsigned set_start;
    clk         = 1'b0;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = '0;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_stall   = 1'b0;
    snd_idle    = 8;
    rcv_idle    = 77;
    hold_reqs   = 0;
    hold_served = 0;
    sent        = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: reset values first
    send_req(make_req(CMD_START, MODE_HELD, 0, 32767));
    send_req(make_req(CMD_SAMPLE, MODE_HELD, 32767, 16'h8000));
    send_req(make_req(CMD_SAMPLE, MODE_RELEASED, 0, 0));
    settle();
    write_reg(CFG_MAX_AMPLITUDE, 16'hffff);
    write_reg(CFG_ATTACK_STEP, 16'hffff);
    write_reg(CFG_RELEASE_STEP, 16'h0000);
    write_reg(CFG_FAST_RELEASE_STEP, 16'hffff);
    write_reg(CFG_GLOBAL_VOLUME, 16'hffff);
    write_reg(CFG_UNUSED_LO, 16'($urandom));
    write_reg(CFG_UNUSED_HI, 16'($urandom));
    // quarter-turn steps walk zero, peak, zero, trough, with saturating mixes
    send_req(make_req(CMD_START, MODE_SILENT, 32767, 0));
    send_req(make_req(CMD_SAMPLE, MODE_HELD, 16384, 0));
    send_req(make_req(CMD_SAMPLE, MODE_HELD, 16384, 32767));
    send_req(make_req(CMD_SAMPLE, MODE_HELD, 16384, 0));
    send_req(make_req(CMD_SAMPLE, MODE_HELD, 16384, 16'h8000));
    send_req(make_req(CMD_SAMPLE, MODE_SILENT, 12345, 100));
    // zero release step keeps the note alive
    send_req(make_req(CMD_SAMPLE, MODE_RELEASED, 1, 16'hffff));
    send_req(make_req(CMD_SAMPLE, MODE_FAST_RELEASE, 32767, 0));
    send_req(make_req(CMD_SAMPLE, MODE_FAST_RELEASE, 5, 0));
    send_req(make_req(CMD_SAMPLE, MODE_RELEASED, 5, 0));
    send_req(make_req(CMD_SAMPLE, MODE_HELD, 777, 0));
    send_req(make_req(CMD_START, MODE_FAST_RELEASE, 1, 16'h8000));
    // release right after start ends the note at once
    send_req(make_req(CMD_SAMPLE, MODE_RELEASED, 300, 0));
    send_req(make_req(CMD_SAMPLE, MODE_HELD, 300, 0));
    settle();
    // lowered ceiling under a louder note
    write_reg(CFG_MAX_AMPLITUDE, 16'd1000);
    send_req(make_req(CMD_SAMPLE, MODE_HELD, 4096, 0));
    send_req(make_req(CMD_SAMPLE, MODE_HELD, 0, 0));
    settle();
    write_reg(CFG_GLOBAL_VOLUME, 16'h0000);
    send_req(make_req(CMD_SAMPLE, MODE_HELD, 4096, 5));

    for (int unsigned p = 0; p < 3; p++) begin
      case (p)
        0: begin snd_idle = 8; rcv_idle = 77; end
        1: begin snd_idle = 77; rcv_idle = 8; end
        default: begin snd_idle = 0; rcv_idle = 0; end
      endcase
      for (int unsigned s = 0; s < 4; s++) begin
        settle();
        apply_setting(s);
        // long result hold-off while requests keep coming
        if (s == 3) hold_reqs++;
        set_start = sent;
        while (sent - set_start < SET_ITEMS) play_note();
      end
    end

    settle();
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
